/* hdl/chtf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtf_pkg: shared types and codes for the chained hash table
// Transfer structs, operation, status and register index codes, byte mask.
// ----------------------------------------------------------------------------
package chtf_pkg;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_BUCKET_COUNT = 3'd0;
  localparam logic [2:0] REG_MAX_KEY_LEN  = 3'd1;
  localparam logic [2:0] REG_MAX_VAL_LEN  = 3'd2;
  localparam logic [2:0] REG_EVICT_REPORT = 3'd3;

  // hash remainder takes one dividend bit per step
  localparam int HASH_STEPS = 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [63:0] value;
    logic [3:0]  val_len;
    logic [3:0]  read_capacity;
  } chtf_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [3:0]  found_len;
    logic        evicted;
    logic [63:0] evicted_key;
    logic [3:0]  evicted_key_len;
    logic [63:0] evicted_value;
    logic [3:0]  evicted_val_len;
  } chtf_out_t;

  // keep the low n bytes of a word
  function automatic logic [63:0] keep_bytes(logic [63:0] v, logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[8*i +: 8] = 8'hFF;
    end
    return v & m;
  endfunction

endpackage

/* hdl/chtf_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtf_hash: bucket index unit
// Big-endian packing of the last four key bytes into a word, then a bit-serial
// restoring remainder by the bucket count, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module chtf_hash
  import chtf_pkg::*;
#(
  parameter int BW  = 7,
  parameter int BIW = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [63:0]    key_i,
  input  logic [3:0]     key_len_i,
  input  logic [BW-1:0]  nb_i,
  output logic           done_o,
  output logic [BIW-1:0] bucket_o
);

  logic          busy_q;
  logic          done_q;
  logic [4:0]    cnt_q;
  logic [31:0]   div_q;
  logic [BW-1:0] rem_q;
  logic [31:0]   sum;
  logic [BW:0]   trial;

  // byte packing, which keeps the last four key bytes
  always_comb begin
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < key_len_i) sum = {sum[23:0], key_i[8*i +: 8]};
    end
  end

  // one restoring remainder step
  always_comb begin
    trial = {rem_q, div_q[31]};
    if (trial >= {1'b0, nb_i}) trial = trial - {1'b0, nb_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_q <= !start_i && busy_q && (cnt_q == 5'(HASH_STEPS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        div_q  <= sum;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= trial[BW-1:0];
        div_q <= {div_q[30:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(HASH_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q[BIW-1:0];

endmodule

/* hdl/chained_hash_table_fifo_evict.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_fifo_evict: key-value store with bucket chains
// Fixed node pool with free list, insertion-order used list and oldest-first
// eviction, run by a sequencer over dual-port node and bucket memories.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | in_data_i (chtf_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (chtf_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item's run time grows with each chain entry walked and with relinking;
// the 32-step remainder in the hash unit dominates.
// After reset and after every write to a defined register a clearing pass
// over max(NODES, BUCKETS) entries rebuilds the lists; no item is taken meanwhile.
// One item is in flight at a time; a waiting result holds the next one back
// only at its final step. Register writes are taken only between items and
// win over an input offered in the same cycle.
module chained_hash_table_fifo_evict
  import chtf_pkg::*;
#(
  parameter int NODES     = 64,
  parameter int BUCKETS   = 64,
  parameter int KEY_BYTES = 8,
  parameter int VAL_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  chtf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output chtf_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PW    = NW + 1;
  localparam int BIW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BW    = $clog2(BUCKETS + 1);
  localparam int CLR_N = (NODES > BUCKETS) ? NODES : BUCKETS;
  localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam int KW    = 8 * KEY_BYTES;
  localparam int VW    = 8 * VAL_BYTES;
  localparam logic [PW-1:0] NIL = PW'(1) << NW;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_HASH  = 5'd2;
  localparam logic [4:0] S_BRD   = 5'd3;
  localparam logic [4:0] S_BH    = 5'd4;
  localparam logic [4:0] S_WALK  = 5'd5;
  localparam logic [4:0] S_CMP   = 5'd6;
  localparam logic [4:0] S_FRD   = 5'd7;
  localparam logic [4:0] S_FGET  = 5'd8;
  localparam logic [4:0] S_ERD   = 5'd9;
  localparam logic [4:0] S_EGET  = 5'd10;
  localparam logic [4:0] S_UNL   = 5'd11;
  localparam logic [4:0] S_FREE1 = 5'd12;
  localparam logic [4:0] S_FREE2 = 5'd13;
  localparam logic [4:0] S_LRD   = 5'd14;
  localparam logic [4:0] S_LNK1  = 5'd15;
  localparam logic [4:0] S_LNK2  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  // memories
  logic [PW-1:0]  bhead_mem [BUCKETS];
  logic [PW-1:0]  lnext_mem [NODES];
  logic [PW-1:0]  lprev_mem [NODES];
  logic [PW-1:0]  cnext_mem [NODES];
  logic [PW-1:0]  cprev_mem [NODES];
  logic [BIW-1:0] ebkt_mem  [NODES];
  logic [KW-1:0]  ekey_mem  [NODES];
  logic [3:0]     eklen_mem [NODES];
  logic [VW-1:0]  eval_mem  [NODES];
  logic [3:0]     evlen_mem [NODES];

  // registered read data
  logic [PW-1:0]  rd_bhead, rd_lnext, rd_lprev, rd_cnext, rd_cprev;
  logic [BIW-1:0] rd_ebkt;
  logic [KW-1:0]  rd_ekey;
  logic [3:0]     rd_eklen, rd_evlen;
  logic [VW-1:0]  rd_eval;

  // write ports
  logic           bh_we, ln_we, lp_we, cn_we, cp_we, key_we, val_we;
  logic [BIW-1:0] bh_wa;
  logic [NW-1:0]  ln_wa, lp_wa, cn_wa, cp_wa;
  logic [PW-1:0]  bh_wd, ln_wd, lp_wd, cn_wd, cp_wd;
  logic [NW-1:0]  node_ra;

  // sequencer state
  logic [4:0]     state_q;
  logic [CW-1:0]  clr_q;
  logic [6:0]     bucket_count_q;
  logic [3:0]     max_key_len_q, max_val_len_q;
  logic           evict_report_q;
  logic [1:0]     op_q;
  logic [KW-1:0]  key_q;
  logic [3:0]     klen_q, vlen_q, cap_q;
  logic [VW-1:0]  val_q;
  logic [BIW-1:0] b_q, bk_q;
  logic [PW-1:0]  cur_q, fh_q, uh_q, ut_q, lnx_q, lpv_q, cnx_q, cpv_q, h_q;
  logic [NW-1:0]  n_q;
  chtf_out_t      res_q, out_q;
  logic           out_valid_q;

  logic [63:0]    in_key_m, in_val_m;
  logic           in_bad, accept, hit, hash_done;
  logic [BIW-1:0] hash_bucket;
  logic [BW-1:0]  nb;
  logic [NW-1:0]  clr_idx;
  logic [PW-1:0]  n_ptr;

  // a pending register write goes first
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign clr_idx     = clr_q[NW-1:0];
  assign n_ptr       = {1'b0, n_q};
  assign hit         = (rd_eklen == klen_q) && (rd_ekey == key_q);

  // input masking and argument check
  assign in_key_m = keep_bytes(in_data_i.key, in_data_i.key_len);
  assign in_val_m = keep_bytes(in_data_i.value, in_data_i.val_len);
  always_comb begin
    in_bad = (in_data_i.key_len == 4'd0) || (in_data_i.key_len > max_key_len_q) ||
             (32'(in_data_i.key_len) > KEY_BYTES);
    if (in_data_i.operation == OP_INSERT || in_data_i.operation == OP_UPDATE) begin
      in_bad = in_bad || (in_data_i.val_len == 4'd0) ||
               (in_data_i.val_len > max_val_len_q) ||
               (32'(in_data_i.val_len) > VAL_BYTES);
    end
  end

  // clamp bucket count into 1..BUCKETS
  always_comb begin
    if (bucket_count_q == 7'd0) nb = BW'(1);
    else if (32'(bucket_count_q) > BUCKETS) nb = BW'(BUCKETS);
    else nb = BW'(bucket_count_q);
  end

  chtf_hash #(
    .BW  (BW),
    .BIW (BIW)
  ) u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && !in_bad),
    .key_i     (in_key_m),
    .key_len_i (in_data_i.key_len),
    .nb_i      (nb),
    .done_o    (hash_done),
    .bucket_o  (hash_bucket)
  );

  // memory write and read port control
  always_comb begin
    bh_we = 1'b0; bh_wa = b_q; bh_wd = NIL;
    ln_we = 1'b0; ln_wa = n_q; ln_wd = NIL;
    lp_we = 1'b0; lp_wa = n_q; lp_wd = NIL;
    cn_we = 1'b0; cn_wa = n_q; cn_wd = NIL;
    cp_we = 1'b0; cp_wa = n_q; cp_wd = NIL;
    key_we = 1'b0;
    val_we = 1'b0;
    node_ra = cur_q[NW-1:0];
    case (state_q)
      S_CLR: begin
        if (32'(clr_q) < BUCKETS) begin
          bh_we = 1'b1;
          bh_wa = clr_q[BIW-1:0];
        end
        if (32'(clr_q) < NODES) begin
          ln_we = 1'b1; ln_wa = clr_idx;
          ln_wd = (clr_idx == '0) ? NIL : {1'b0, clr_idx - NW'(1)};
          lp_we = 1'b1; lp_wa = clr_idx;
          lp_wd = (32'(clr_idx) == NODES - 1) ? NIL : {1'b0, clr_idx + NW'(1)};
          cn_we = 1'b1; cn_wa = clr_idx;
          cp_we = 1'b1; cp_wa = clr_idx;
        end
      end
      S_CMP: begin
        if (hit && (op_q == OP_INSERT || op_q == OP_UPDATE)) begin
          val_we = 1'b1;
          ln_wa  = cur_q[NW-1:0];
        end
      end
      S_FRD: node_ra = fh_q[NW-1:0];
      S_FGET: begin
        if (!rd_lnext[NW]) begin
          lp_we = 1'b1; lp_wa = rd_lnext[NW-1:0]; lp_wd = NIL;
        end
      end
      S_ERD: node_ra = ut_q[NW-1:0];
      S_UNL: begin
        if (!lnx_q[NW]) begin
          lp_we = 1'b1; lp_wa = lnx_q[NW-1:0]; lp_wd = lpv_q;
        end
        if (!lpv_q[NW]) begin
          ln_we = 1'b1; ln_wa = lpv_q[NW-1:0]; ln_wd = lnx_q;
        end
        if (!cnx_q[NW]) begin
          cp_we = 1'b1; cp_wa = cnx_q[NW-1:0]; cp_wd = cpv_q;
        end
        if (!cpv_q[NW]) begin
          cn_we = 1'b1; cn_wa = cpv_q[NW-1:0]; cn_wd = cnx_q;
        end else begin
          bh_we = 1'b1; bh_wa = bk_q; bh_wd = cnx_q;
        end
      end
      S_FREE1: begin
        ln_we = 1'b1; ln_wd = fh_q;
        lp_we = 1'b1;
        cn_we = 1'b1;
        cp_we = 1'b1;
      end
      S_FREE2: begin
        if (!fh_q[NW]) begin
          lp_we = 1'b1; lp_wa = fh_q[NW-1:0]; lp_wd = n_ptr;
        end
      end
      S_LNK1: begin
        key_we = 1'b1;
        val_we = 1'b1;
        ln_we = 1'b1; ln_wd = uh_q;
        lp_we = 1'b1;
        cn_we = 1'b1; cn_wd = rd_bhead;
        cp_we = 1'b1;
        bh_we = 1'b1; bh_wd = n_ptr;
      end
      S_LNK2: begin
        if (!uh_q[NW]) begin
          lp_we = 1'b1; lp_wa = uh_q[NW-1:0]; lp_wd = n_ptr;
        end
        if (!h_q[NW]) begin
          cp_we = 1'b1; cp_wa = h_q[NW-1:0]; cp_wd = n_ptr;
        end
      end
      default: ;
    endcase
  end

  // memory arrays, registered reads
  always_ff @(posedge clk_i) begin
    if (bh_we) bhead_mem[bh_wa] <= bh_wd;
    if (ln_we) lnext_mem[ln_wa] <= ln_wd;
    if (lp_we) lprev_mem[lp_wa] <= lp_wd;
    if (cn_we) cnext_mem[cn_wa] <= cn_wd;
    if (cp_we) cprev_mem[cp_wa] <= cp_wd;
    if (key_we) begin
      ekey_mem[n_q]  <= key_q;
      eklen_mem[n_q] <= klen_q;
      ebkt_mem[n_q]  <= b_q;
    end
    if (val_we) begin
      eval_mem[ln_wa]  <= val_q;
      evlen_mem[ln_wa] <= vlen_q;
    end
    rd_bhead <= bhead_mem[b_q];
    rd_lnext <= lnext_mem[node_ra];
    rd_lprev <= lprev_mem[node_ra];
    rd_cnext <= cnext_mem[node_ra];
    rd_cprev <= cprev_mem[node_ra];
    rd_ebkt  <= ebkt_mem[node_ra];
    rd_ekey  <= ekey_mem[node_ra];
    rd_eklen <= eklen_mem[node_ra];
    rd_eval  <= eval_mem[node_ra];
    rd_evlen <= evlen_mem[node_ra];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      clr_q          <= '0;
      bucket_count_q <= 7'd64;
      max_key_len_q  <= 4'd8;
      max_val_len_q  <= 4'd8;
      evict_report_q <= 1'b0;
      op_q           <= OP_INSERT;
      key_q          <= '0;
      klen_q         <= '0;
      val_q          <= '0;
      vlen_q         <= '0;
      cap_q          <= '0;
      b_q            <= '0;
      bk_q           <= '0;
      cur_q          <= NIL;
      fh_q           <= NIL;
      uh_q           <= NIL;
      ut_q           <= NIL;
      lnx_q          <= NIL;
      lpv_q          <= NIL;
      cnx_q          <= NIL;
      cpv_q          <= NIL;
      h_q            <= NIL;
      n_q            <= '0;
      res_q          <= '0;
      out_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      // result register empties on its transfer unless refilled below
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == CW'(CLR_N - 1)) begin
            state_q <= S_IDLE;
            fh_q    <= {1'b0, NW'(NODES - 1)};
            uh_q    <= NIL;
            ut_q    <= NIL;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q   <= in_data_i.operation;
            key_q  <= KW'(in_key_m);
            klen_q <= in_data_i.key_len;
            val_q  <= VW'(in_val_m);
            vlen_q <= in_data_i.val_len;
            cap_q  <= in_data_i.read_capacity;
            if (in_bad) begin
              res_q.status <= ST_INVALID;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            b_q     <= hash_bucket;
            state_q <= S_BRD;
          end
        end
        S_BRD: state_q <= S_BH;
        S_BH: begin
          cur_q   <= rd_bhead;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (cur_q[NW]) begin
            if (op_q == OP_INSERT) begin
              if (!fh_q[NW]) state_q <= S_FRD;
              else if (!ut_q[NW]) state_q <= S_ERD;
              else begin
                res_q.status <= ST_INVALID;
                state_q      <= S_DONE;
              end
            end else begin
              res_q.status <= ST_NOT_FOUND;
              state_q      <= S_DONE;
            end
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            n_q   <= cur_q[NW-1:0];
            lnx_q <= rd_lnext;
            lpv_q <= rd_lprev;
            cnx_q <= rd_cnext;
            cpv_q <= rd_cprev;
            bk_q  <= rd_ebkt;
            case (op_q)
              OP_REMOVE: state_q <= S_UNL;
              OP_FIND: begin
                if (rd_evlen > cap_q) begin
                  res_q.status      <= ST_TRUNC;
                  res_q.found_value <= keep_bytes(64'(rd_eval), cap_q);
                  res_q.found_len   <= cap_q;
                end else begin
                  res_q.found_value <= keep_bytes(64'(rd_eval), rd_evlen);
                  res_q.found_len   <= rd_evlen;
                end
                state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end else begin
            cur_q   <= rd_cnext;
            state_q <= S_WALK;
          end
        end
        S_FRD: state_q <= S_FGET;
        S_FGET: begin
          n_q     <= fh_q[NW-1:0];
          fh_q    <= rd_lnext;
          state_q <= S_LRD;
        end
        S_ERD: state_q <= S_EGET;
        S_EGET: begin
          n_q   <= ut_q[NW-1:0];
          lnx_q <= rd_lnext;
          lpv_q <= rd_lprev;
          cnx_q <= rd_cnext;
          cpv_q <= rd_cprev;
          bk_q  <= rd_ebkt;
          if (evict_report_q) begin
            res_q.evicted         <= 1'b1;
            res_q.evicted_key     <= 64'(rd_ekey);
            res_q.evicted_key_len <= rd_eklen;
            res_q.evicted_value   <= 64'(rd_eval);
            res_q.evicted_val_len <= rd_evlen;
          end
          state_q <= S_UNL;
        end
        S_UNL: begin
          if (lnx_q[NW]) ut_q <= lpv_q;
          if (lpv_q[NW]) uh_q <= lnx_q;
          state_q <= (op_q == OP_REMOVE) ? S_FREE1 : S_LRD;
        end
        S_FREE1: state_q <= S_FREE2;
        S_FREE2: begin
          fh_q    <= n_ptr;
          state_q <= S_DONE;
        end
        S_LRD: state_q <= S_LNK1;
        S_LNK1: begin
          h_q     <= rd_bhead;
          state_q <= S_LNK2;
        end
        S_LNK2: begin
          if (uh_q[NW]) ut_q <= n_ptr;
          uh_q    <= n_ptr;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hand the result over and start the next one from zero
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            res_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_CLR;
      endcase

      // register write; a write to a defined register also clears the table
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BUCKET_COUNT: bucket_count_q <= cfg_data_i[6:0];
          REG_MAX_KEY_LEN:  max_key_len_q  <= cfg_data_i[3:0];
          REG_MAX_VAL_LEN:  max_val_len_q  <= cfg_data_i[3:0];
          REG_EVICT_REPORT: evict_report_q <= cfg_data_i[0];
          default: ;
        endcase
        if (cfg_index_i == REG_BUCKET_COUNT || cfg_index_i == REG_MAX_KEY_LEN ||
            cfg_index_i == REG_MAX_VAL_LEN || cfg_index_i == REG_EVICT_REPORT) begin
          state_q <= S_CLR;
          clr_q   <= '0;
        end
      end
    end
  end

endmodule
